// ===== rtl/ks_pkg.sv =====
// Shared types and constants for the key sorter.
// No dependencies; used by ks_cell and key_sorter.
package ks_pkg;

    localparam int DEF_MAX_KEYS  = 64;
    localparam int DEF_KEY_WIDTH = 32;
    localparam int FIELD_WIDTH   = 32;
    localparam int MODE_WIDTH    = 2;

    // Bit positions in the compare mode register.
    localparam int MODE_SIGNED_BIT = 0;
    localparam int MODE_DESC_BIT   = 1;

    localparam logic [MODE_WIDTH-1:0] MODE_RESET = MODE_WIDTH'(0);

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                  load;
        logic                  emit;
        logic [MODE_WIDTH-1:0] mode;
    } ks_ctrl_t;

endpackage

// ===== rtl/ks_cell.sv =====
// One cell of the insertion chain: holds a key and its valid bit.
// Depends on ks_pkg for the control struct and the mode bit positions.
module ks_cell #(
    parameter int KEY_WIDTH = ks_pkg::DEF_KEY_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ks_pkg::ks_ctrl_t     ctrl,
    input  logic [KEY_WIDTH-1:0] new_key,
    input  logic                 left_ins,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic                 left_valid,
    input  logic [KEY_WIDTH-1:0] right_key,
    input  logic                 right_valid,
    output logic                 ins,
    output logic [KEY_WIDTH-1:0] key,
    output logic                 valid
);

    localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic [KEY_WIDTH-1:0] flip;
    logic [KEY_WIDTH-1:0] new_cmp;
    logic [KEY_WIDTH-1:0] own_cmp;
    logic                 goes_first;

    // Biased compare turns two's complement order into unsigned order.
    assign flip       = ctrl.mode[ks_pkg::MODE_SIGNED_BIT] ? SIGN_BIT : '0;
    assign new_cmp    = new_key ^ flip;
    assign own_cmp    = key_reg ^ flip;
    assign goes_first = ctrl.mode[ks_pkg::MODE_DESC_BIT] ? (new_cmp > own_cmp)
                                                         : (new_cmp < own_cmp);

    // The new key belongs at or left of this cell.
    assign ins = !valid_reg || goes_first;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.emit)
        begin
            // advance toward the head
            key_next   = right_key;
            valid_next = right_valid;
        end
        else if (ctrl.load)
        begin
            if (left_ins)
            begin
                key_next   = left_key;
                valid_next = left_valid;
            end
            else if (ins)
            begin
                key_next   = new_key;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

// ===== rtl/key_sorter.sv =====
// Top level of the key sorter: sequencer, configuration register and the cell chain.
// Depends on ks_pkg and ks_cell.
//
// The key sorter collects a set of keys and returns them sorted. A key word
// is taken at any clock edge with start high and busy low, one per cycle,
// and goes straight into its sorted place in a chain of MAX_KEYS cells. The
// word with last_in high closes the set (a dropped key with last_in still
// closes it). From the next cycle busy is high and the block drives one
// sorted key per cycle on sorted_key with result_valid high for that cycle
// only; there is no backpressure, the receiver must take each word as it
// appears. The output is the chain shifting one cell a cycle toward its
// head. last_out marks the final word; overflow is high on every word of a
// set that lost keys because the chain was full. compare_mode (0 unsigned
// up, 1 signed up, 2 unsigned down, 3 signed down) is written through the
// cfg port, which is always ready, and should only change while no set is
// being loaded or emitted.
module key_sorter #(
    parameter int MAX_KEYS  = ks_pkg::DEF_MAX_KEYS,
    parameter int KEY_WIDTH = ks_pkg::DEF_KEY_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ks_pkg::FIELD_WIDTH-1:0]     key,
    input  logic                               last_in,
    output logic                               result_valid,
    output logic [ks_pkg::FIELD_WIDTH-1:0]     sorted_key,
    output logic                               last_out,
    output logic                               overflow,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ks_pkg::MODE_WIDTH-1:0]      cfg_data
);

    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int FW = ks_pkg::FIELD_WIDTH;
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_KEYS);
    localparam logic [CW-1:0] COUNT_ONE  = CW'(1);

    logic [ks_pkg::MODE_WIDTH-1:0] mode_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          dropped_reg;
    logic                          dropped_next;
    logic                          emit_reg;
    logic                          emit_next;

    logic                          accept;
    logic                          full;
    ks_pkg::ks_ctrl_t              ctrl;

    logic [KEY_WIDTH+FW-1:0]       key_wide;
    logic [KEY_WIDTH-1:0]          new_key;
    logic [KEY_WIDTH+FW-1:0]       out_wide;

    logic [KEY_WIDTH-1:0]          cell_key   [MAX_KEYS];
    logic [MAX_KEYS-1:0]           cell_valid;
    logic [MAX_KEYS-1:0]           cell_ins;

    assign accept    = start && !busy;
    assign full      = (count_reg == COUNT_FULL);
    assign busy      = emit_reg;
    assign cfg_ready = 1'b1;

    // Resize the key field to the stored key width.
    assign key_wide = {{KEY_WIDTH{1'b0}}, key};
    assign new_key  = key_wide[KEY_WIDTH-1:0];

    assign ctrl.load = accept && !full;
    assign ctrl.emit = emit_reg;
    assign ctrl.mode = mode_reg;

    // Configuration register: take the word whenever offered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ks_pkg::MODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Sequencer: count keys while loading, count down while emitting.
    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        emit_next    = emit_reg;
        if (emit_reg)
        begin
            count_next = count_reg - COUNT_ONE;
            if (count_reg == COUNT_ONE)
            begin
                // final word goes out: clear the set
                emit_next    = 1'b0;
                dropped_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + COUNT_ONE;
            end
            if (last_in)
            begin
                emit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            emit_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            emit_reg    <= emit_next;
        end
    end

    // Cell chain: cell 0 holds the head of the sorted order.
    for (genvar g = 0; g < MAX_KEYS; g++)
    begin : g_cell
        logic                 left_ins;
        logic [KEY_WIDTH-1:0] left_key;
        logic                 left_valid;
        logic [KEY_WIDTH-1:0] right_key;
        logic                 right_valid;

        if (g == 0)
        begin : g_head
            assign left_ins   = 1'b0;
            assign left_key   = '0;
            assign left_valid = 1'b0;
        end
        else
        begin : g_body
            assign left_ins   = cell_ins[g-1];
            assign left_key   = cell_key[g-1];
            assign left_valid = cell_valid[g-1];
        end

        if (g == MAX_KEYS - 1)
        begin : g_tail
            assign right_key   = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner
            assign right_key   = cell_key[g+1];
            assign right_valid = cell_valid[g+1];
        end

        ks_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_key     (new_key),
            .left_ins    (left_ins),
            .left_key    (left_key),
            .left_valid  (left_valid),
            .right_key   (right_key),
            .right_valid (right_valid),
            .ins         (cell_ins[g]),
            .key         (cell_key[g]),
            .valid       (cell_valid[g])
        );
    end

    // Results come straight from the head cell.
    assign out_wide     = {{FW{1'b0}}, cell_key[0]};
    assign sorted_key   = out_wide[FW-1:0];
    assign result_valid = emit_reg;
    assign last_out     = emit_reg && (count_reg == COUNT_ONE);
    assign overflow     = emit_reg && dropped_reg;

`ifndef NO_ASSERTIONS
    // Every emitted word comes from a filled head cell.
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg |-> cell_valid[0])
        else $error("emitting from an empty head cell");

    // Filled cells always match the key count.
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("cell valid bits disagree with key count");

    // Keys are dropped only into a full chain; the flag holds while the set drains.
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        dropped_reg |-> (full || emit_reg))
        else $error("drop flag set with room left");

    // The final word ends the burst.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        last_out |=> !result_valid && count_reg == '0)
        else $error("results continue after the final word");
`endif

endmodule
